/* hw/rtl/mbad_pkg.sv */
package mbad_pkg;

  // Default sizes of the top level
  localparam int DEFAULT_MAX_BINS    = 4096;
  localparam int DEFAULT_MAX_DIM     = 1024;
  localparam int DEFAULT_SAMPLE_BITS = 16;

  // Fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int AVG_W      = 16;
  localparam int BINIDX_W   = 10;
  localparam int TBLOCK_W   = 16;
  localparam int ROWS_W     = 11;
  localparam int COLS_W     = 11;
  localparam int SF_W       = 5;
  localparam int TF_W       = 7;
  localparam int FRAMES_W   = 16;
  localparam int FIG_W      = 6;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // Register limits and reset values
  localparam int SF_MAX        = 16;
  localparam int TF_MAX        = 64;
  localparam int ROWS_RESET    = 512;
  localparam int COLS_RESET    = 512;
  localparam int SF_RESET      = 2;
  localparam int TF_RESET      = 1;
  localparam int FRAMES_RESET  = 1000;
  localparam int DIM_REG_MAX   = 2047;

  // Element count of a block: up to 16 * 16 * 64
  localparam int CNT_W   = 15;
  localparam int CNT_LOG = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS   = 3'd0,
    REG_COLS   = 3'd1,
    REG_SPACE  = 3'd2,
    REG_TIME   = 3'd3,
    REG_FRAMES = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* hw/rtl/mbad_ram.sv */
module mbad_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word when the same entry is written in the same cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/mbad_div.sv */
module mbad_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NUM_W-1:0]       num,
  input  logic [DEN_W-1:0]       den,
  output mbad_pkg::div_status_t  status,
  output logic [NUM_W-1:0]       quot,
  output logic [DEN_W-1:0]       rem
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] work;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CntW-1:0]  count;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  // One restoring step per cycle, quotient bits shift in from the bottom
  assign shifted = {rem_q, work[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CntW'(NUM_W);
      end else if (busy) begin
        count <= count - CntW'(1);
        if (count == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work  <= num;
      rem_q <= '0;
      den_q <= den;
    end else if (busy) begin
      work  <= {work[NUM_W-2:0], fits};
      rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quot        = work;
  assign rem         = rem_q;

endmodule

/* hw/rtl/movie_block_average_downsample.sv */
// Throughput: one pixel per cycle while no bin completes; a pixel that completes a bin
//   holds the input until its mean is loaded into the output register, as the block's
//   mean comes from the shared one-bit-per-cycle divider (30-bit dividend by default).
// A bin's last pixel passes the update stage, then the divider, then the output register.
// Reset (synchronous, rst high) and every register write start a setup of 5 divisions
//   plus the multiply states MUL1 and MUL2, during which no pixel is taken.
module movie_block_average_downsample #(
  parameter int MAX_BINS    = mbad_pkg::DEFAULT_MAX_BINS,
  parameter int MAX_DIM     = mbad_pkg::DEFAULT_MAX_DIM,
  parameter int SAMPLE_BITS = mbad_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [mbad_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbad_pkg::CFG_DATA_W-1:0]   cfg_data,
  // pixel input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mbad_pkg::SAMPLE_W-1:0]     sample,
  // result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mbad_pkg::AVG_W-1:0]        average,
  output logic [mbad_pkg::BINIDX_W-1:0]     bin_row,
  output logic [mbad_pkg::BINIDX_W-1:0]     bin_col,
  output logic [mbad_pkg::TBLOCK_W-1:0]     time_block,
  output logic                              last_of_group
);

  // Bits of a sample that count, and the width of a bin sum
  localparam int SampleBits = SAMPLE_BITS < mbad_pkg::SAMPLE_W ? SAMPLE_BITS
                                                               : mbad_pkg::SAMPLE_W;
  localparam int SumW       = SampleBits + mbad_pkg::CNT_LOG;
  localparam int DivNumW    = SumW > mbad_pkg::FRAMES_W ? SumW : mbad_pkg::FRAMES_W;
  localparam int DivDenW    = mbad_pkg::CNT_W;
  // Largest image dimension the registers can reach under MAX_DIM
  localparam int DimCap     = MAX_DIM < mbad_pkg::DIM_REG_MAX ? MAX_DIM
                                                              : mbad_pkg::DIM_REG_MAX;
  localparam int DimW       = $clog2(DimCap + 1);
  localparam int PosW       = DimCap > 1 ? $clog2(DimCap) : 1;
  localparam int BinW       = MAX_BINS > 1 ? $clog2(MAX_BINS) : 1;
  localparam int AddrW      = (2 * DimW > BinW + 1) ? 2 * DimW : BinW + 1;
  localparam int SfSqW      = 2 * mbad_pkg::SF_W;

  typedef enum logic [1:0] {
    ST_SETUP,
    ST_MUL1,
    ST_MUL2,
    ST_RUN
  } state_t;

  typedef enum logic [2:0] {
    SS_NBR,
    SS_NBC,
    SS_ROW,
    SS_COL,
    SS_GROUPS
  } setup_step_t;

  state_t      state;
  setup_step_t step;
  logic        setup_go;

  // Configuration registers, raw as written
  logic [mbad_pkg::ROWS_W-1:0]   rows_reg;
  logic [mbad_pkg::COLS_W-1:0]   cols_reg;
  logic [mbad_pkg::SF_W-1:0]     sf_reg;
  logic [mbad_pkg::TF_W-1:0]     tf_reg;
  logic [mbad_pkg::FRAMES_W-1:0] frames_reg;

  // Clamped register values
  logic [DimW-1:0]               r_eff;
  logic [DimW-1:0]               c_eff;
  logic [mbad_pkg::SF_W-1:0]     sf_eff;
  logic [mbad_pkg::TF_W-1:0]     tf_eff;
  logic [mbad_pkg::FRAMES_W-1:0] nf_eff;

  // Values derived during setup
  logic [DimW-1:0]               nbr;
  logic [DimW-1:0]               nbc;
  logic [mbad_pkg::FRAMES_W-1:0] ngroups;
  logic [AddrW-1:0]              nbins;
  logic [AddrW-1:0]              lastaddr;
  logic [SfSqW-1:0]              sf_sq;
  logic [mbad_pkg::CNT_W-1:0]    cnt;

  // Scan position, kept both as raw position and as bin index plus offset
  logic [PosW-1:0]               row_pos;
  logic [mbad_pkg::SF_W-1:0]     row_sub;
  logic [PosW-1:0]               bin_r;
  logic [PosW-1:0]               col_pos;
  logic [mbad_pkg::SF_W-1:0]     col_sub;
  logic [PosW-1:0]               bin_c;
  logic [AddrW-1:0]              col_base;
  logic [mbad_pkg::FRAMES_W-1:0] frame_count;
  logic [mbad_pkg::FIG_W-1:0]    frame_in_group;
  logic [mbad_pkg::TBLOCK_W-1:0] group_index;

  logic [PosW-1:0]               row_pos_next;
  logic [mbad_pkg::SF_W-1:0]     row_sub_next;
  logic [PosW-1:0]               bin_r_next;
  logic [PosW-1:0]               col_pos_next;
  logic [mbad_pkg::SF_W-1:0]     col_sub_next;
  logic [PosW-1:0]               bin_c_next;
  logic [AddrW-1:0]              col_base_next;
  logic [mbad_pkg::FRAMES_W-1:0] frame_count_next;
  logic [mbad_pkg::FIG_W-1:0]    frame_in_group_next;
  logic [mbad_pkg::TBLOCK_W-1:0] group_index_next;

  // Accept stage decode
  logic                          in_accept;
  logic [AddrW-1:0]              addr_a;
  logic                          bin_ok_a;
  logic                          first_a;
  logic                          last_a;
  logic [SumW-1:0]               sample_a;

  // Update stage: read data is back, add and write the sum
  logic                          b_valid;
  logic                          b_first;
  logic                          b_last;
  logic                          b_lastbin;
  logic [BinW-1:0]               b_addr;
  logic [SumW-1:0]               b_sample;
  logic [PosW-1:0]               b_br;
  logic [PosW-1:0]               b_bc;
  logic [mbad_pkg::TBLOCK_W-1:0] b_group;
  logic [SumW-1:0]               b_sum;
  logic [SumW-1:0]               b_base;
  logic                          fwd_sel;
  logic [SumW-1:0]               fwd_val;
  logic [SumW-1:0]               ram_rdata;

  // Result waiting on the divider
  logic                          div_pend;
  logic                          avg_wait;
  logic                          p_lastbin;
  logic [PosW-1:0]               p_br;
  logic [PosW-1:0]               p_bc;
  logic [mbad_pkg::TBLOCK_W-1:0] p_group;

  // Shared divider
  logic                          div_start;
  logic [DivNumW-1:0]            div_num;
  logic [DivDenW-1:0]            div_den;
  mbad_pkg::div_status_t         div_status;
  logic [DivNumW-1:0]            div_quot;
  logic [DivDenW-1:0]            div_rem;

  // Clamp registers: zero counts as one; rows, columns and factors saturate when large
  always_comb begin
    if (rows_reg == '0) begin
      r_eff = DimW'(1);
    end else if (rows_reg > mbad_pkg::ROWS_W'(DimCap)) begin
      r_eff = DimW'(DimCap);
    end else begin
      r_eff = DimW'(rows_reg);
    end
    if (cols_reg == '0) begin
      c_eff = DimW'(1);
    end else if (cols_reg > mbad_pkg::COLS_W'(DimCap)) begin
      c_eff = DimW'(DimCap);
    end else begin
      c_eff = DimW'(cols_reg);
    end
    if (sf_reg == '0) begin
      sf_eff = mbad_pkg::SF_W'(1);
    end else if (sf_reg > mbad_pkg::SF_W'(mbad_pkg::SF_MAX)) begin
      sf_eff = mbad_pkg::SF_W'(mbad_pkg::SF_MAX);
    end else begin
      sf_eff = sf_reg;
    end
    if (tf_reg == '0) begin
      tf_eff = mbad_pkg::TF_W'(1);
    end else if (tf_reg > mbad_pkg::TF_W'(mbad_pkg::TF_MAX)) begin
      tf_eff = mbad_pkg::TF_W'(mbad_pkg::TF_MAX);
    end else begin
      tf_eff = tf_reg;
    end
    nf_eff = (frames_reg == '0) ? mbad_pkg::FRAMES_W'(1) : frames_reg;
  end

  // Accept-stage decode of the current position
  assign in_ready  = (state == ST_RUN) && !div_pend && !(b_valid && b_last);
  assign in_accept = in_valid && in_ready;
  assign sample_a  = SumW'(sample[SampleBits-1:0]);
  assign addr_a    = AddrW'(bin_r) + col_base;
  assign bin_ok_a  = (AddrW'(bin_r) < AddrW'(nbr)) && (AddrW'(bin_c) < AddrW'(nbc)) &&
                     (group_index < ngroups) && (addr_a < AddrW'(MAX_BINS));
  assign first_a   = (frame_in_group == '0) && (row_sub == '0) && (col_sub == '0);
  assign last_a    = (mbad_pkg::TF_W'(frame_in_group) == tf_eff - mbad_pkg::TF_W'(1)) &&
                     (row_sub == sf_eff - mbad_pkg::SF_W'(1)) &&
                     (col_sub == sf_eff - mbad_pkg::SF_W'(1));

  // Advance the scan position by one pixel
  always_comb begin
    logic [PosW:0]                 row_inc;
    logic [PosW:0]                 col_inc;
    logic [mbad_pkg::SF_W-1:0]     rsub_inc;
    logic [mbad_pkg::SF_W-1:0]     csub_inc;
    logic [mbad_pkg::TF_W-1:0]     fig_inc;
    logic [mbad_pkg::FRAMES_W:0]   fc_inc;

    row_inc  = {1'b0, row_pos} + (PosW + 1)'(1);
    col_inc  = {1'b0, col_pos} + (PosW + 1)'(1);
    rsub_inc = row_sub + mbad_pkg::SF_W'(1);
    csub_inc = col_sub + mbad_pkg::SF_W'(1);
    fig_inc  = mbad_pkg::TF_W'(frame_in_group) + mbad_pkg::TF_W'(1);
    fc_inc   = {1'b0, frame_count} + (mbad_pkg::FRAMES_W + 1)'(1);

    row_pos_next        = row_inc[PosW-1:0];
    row_sub_next        = rsub_inc;
    bin_r_next          = bin_r;
    col_pos_next        = col_pos;
    col_sub_next        = col_sub;
    bin_c_next          = bin_c;
    col_base_next       = col_base;
    frame_count_next    = frame_count;
    frame_in_group_next = frame_in_group;
    group_index_next    = group_index;

    if (rsub_inc == sf_eff) begin
      row_sub_next = '0;
      bin_r_next   = bin_r + PosW'(1);
    end

    if (row_inc >= (PosW + 1)'(r_eff)) begin
      // end of a column: wrap the row and step the column
      row_pos_next = '0;
      row_sub_next = '0;
      bin_r_next   = '0;
      col_pos_next = col_inc[PosW-1:0];
      col_sub_next = csub_inc;
      if (csub_inc == sf_eff) begin
        col_sub_next  = '0;
        bin_c_next    = bin_c + PosW'(1);
        col_base_next = col_base + AddrW'(nbr);
      end
      if (col_inc >= (PosW + 1)'(c_eff)) begin
        // end of a frame
        col_pos_next        = '0;
        col_sub_next        = '0;
        bin_c_next          = '0;
        col_base_next       = '0;
        frame_count_next    = fc_inc[mbad_pkg::FRAMES_W-1:0];
        frame_in_group_next = fig_inc[mbad_pkg::FIG_W-1:0];
        if (fig_inc >= tf_eff) begin
          frame_in_group_next = '0;
          group_index_next    = group_index + mbad_pkg::TBLOCK_W'(1);
        end
        if (fc_inc >= {1'b0, nf_eff}) begin
          frame_count_next    = '0;
          frame_in_group_next = '0;
          group_index_next    = '0;
        end
      end
    end
  end

  // Sum for the update stage; forward the previous write when it hit the same bin
  assign b_base = fwd_sel ? fwd_val : ram_rdata;
  assign b_sum  = b_first ? b_sample : b_base + b_sample;

  // Divider operand select: setup divisions, then block means
  always_comb begin
    div_start = 1'b0;
    div_num   = DivNumW'(b_sum);
    div_den   = cnt;
    if (state == ST_SETUP) begin
      div_start = setup_go;
      div_den   = DivDenW'(sf_eff);
      unique case (step)
        SS_NBR:    div_num = DivNumW'(r_eff);
        SS_NBC:    div_num = DivNumW'(c_eff);
        SS_ROW:    div_num = DivNumW'(row_pos);
        SS_COL:    div_num = DivNumW'(col_pos);
        SS_GROUPS: begin
          div_num = DivNumW'(nf_eff);
          div_den = DivDenW'(tf_eff);
        end
      endcase
    end else if (state == ST_RUN) begin
      div_start = b_valid && b_last;
    end
  end

  mbad_div #(
    .NUM_W (DivNumW),
    .DEN_W (DivDenW)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .status (div_status),
    .quot   (div_quot),
    .rem    (div_rem)
  );

  mbad_ram #(
    .WIDTH (SumW),
    .DEPTH (MAX_BINS)
  ) u_sums (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_addr),
    .wdata (b_sum),
    .raddr (addr_a[BinW-1:0]),
    .rdata (ram_rdata)
  );

  // Control: state, setup sequence, registers, scan counters, result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_SETUP;
      step           <= SS_NBR;
      setup_go       <= 1'b1;
      rows_reg       <= mbad_pkg::ROWS_W'(mbad_pkg::ROWS_RESET);
      cols_reg       <= mbad_pkg::COLS_W'(mbad_pkg::COLS_RESET);
      sf_reg         <= mbad_pkg::SF_W'(mbad_pkg::SF_RESET);
      tf_reg         <= mbad_pkg::TF_W'(mbad_pkg::TF_RESET);
      frames_reg     <= mbad_pkg::FRAMES_W'(mbad_pkg::FRAMES_RESET);
      nbr            <= '0;
      nbc            <= '0;
      ngroups        <= '0;
      nbins          <= '0;
      lastaddr       <= '0;
      sf_sq          <= '0;
      cnt            <= '0;
      row_pos        <= '0;
      row_sub        <= '0;
      bin_r          <= '0;
      col_pos        <= '0;
      col_sub        <= '0;
      bin_c          <= '0;
      col_base       <= '0;
      frame_count    <= '0;
      frame_in_group <= '0;
      group_index    <= '0;
      b_valid        <= 1'b0;
      fwd_sel        <= 1'b0;
      div_pend       <= 1'b0;
      avg_wait       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        // Take the write and rerun setup; the scan counters are kept
        unique case (cfg_index)
          mbad_pkg::REG_ROWS:   rows_reg   <= cfg_data[mbad_pkg::ROWS_W-1:0];
          mbad_pkg::REG_COLS:   cols_reg   <= cfg_data[mbad_pkg::COLS_W-1:0];
          mbad_pkg::REG_SPACE:  sf_reg     <= cfg_data[mbad_pkg::SF_W-1:0];
          mbad_pkg::REG_TIME:   tf_reg     <= cfg_data[mbad_pkg::TF_W-1:0];
          mbad_pkg::REG_FRAMES: frames_reg <= cfg_data[mbad_pkg::FRAMES_W-1:0];
          default: ;
        endcase
        state    <= ST_SETUP;
        step     <= SS_NBR;
        setup_go <= 1'b1;
      end else begin
        unique case (state)
          ST_SETUP: begin
            if (setup_go) begin
              setup_go <= 1'b0;
            end else if (div_status.done) begin
              setup_go <= 1'b1;
              unique case (step)
                SS_NBR: begin
                  nbr  <= div_quot[DimW-1:0];
                  step <= SS_NBC;
                end
                SS_NBC: begin
                  nbc  <= div_quot[DimW-1:0];
                  step <= SS_ROW;
                end
                SS_ROW: begin
                  bin_r   <= div_quot[PosW-1:0];
                  row_sub <= div_rem[mbad_pkg::SF_W-1:0];
                  step    <= SS_COL;
                end
                SS_COL: begin
                  bin_c   <= div_quot[PosW-1:0];
                  col_sub <= div_rem[mbad_pkg::SF_W-1:0];
                  step    <= SS_GROUPS;
                end
                SS_GROUPS: begin
                  ngroups  <= div_quot[mbad_pkg::FRAMES_W-1:0];
                  setup_go <= 1'b0;
                  state    <= ST_MUL1;
                end
              endcase
            end
          end
          ST_MUL1: begin
            nbins    <= AddrW'(nbr * nbc);
            col_base <= AddrW'(nbr * bin_c);
            sf_sq    <= sf_eff * sf_eff;
            state    <= ST_MUL2;
          end
          ST_MUL2: begin
            cnt <= mbad_pkg::CNT_W'(sf_sq * tf_eff);
            if (nbins < AddrW'(MAX_BINS)) begin
              lastaddr <= nbins - AddrW'(1);
            end else begin
              lastaddr <= AddrW'(MAX_BINS - 1);
            end
            state <= ST_RUN;
          end
          ST_RUN: begin
            if (in_accept) begin
              row_pos        <= row_pos_next;
              row_sub        <= row_sub_next;
              bin_r          <= bin_r_next;
              col_pos        <= col_pos_next;
              col_sub        <= col_sub_next;
              bin_c          <= bin_c_next;
              col_base       <= col_base_next;
              frame_count    <= frame_count_next;
              frame_in_group <= frame_in_group_next;
              group_index    <= group_index_next;
            end
          end
        endcase
      end

      // Pixels that fall outside a whole block or group, or past the sum store, drop here
      b_valid <= in_accept && bin_ok_a;
      fwd_sel <= in_accept && b_valid && (b_addr == addr_a[BinW-1:0]);

      if (state == ST_RUN && b_valid && b_last) begin
        div_pend <= 1'b1;
      end
      if (state == ST_RUN && div_pend && div_status.done) begin
        avg_wait <= 1'b1;
      end

      // Output register: load a finished mean when the slot is free
      if (avg_wait && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        avg_wait  <= 1'b0;
        div_pend  <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_first   <= first_a;
      b_last    <= last_a;
      b_lastbin <= addr_a == lastaddr;
      b_addr    <= addr_a[BinW-1:0];
      b_sample  <= sample_a;
      b_br      <= bin_r;
      b_bc      <= bin_c;
      b_group   <= group_index;
    end
    fwd_val <= b_sum;
    if (b_valid && b_last) begin
      p_lastbin <= b_lastbin;
      p_br      <= b_br;
      p_bc      <= b_bc;
      p_group   <= b_group;
    end
    if (avg_wait && (!out_valid || out_ready)) begin
      average       <= div_quot[mbad_pkg::AVG_W-1:0];
      bin_row       <= mbad_pkg::BINIDX_W'(p_br);
      bin_col       <= mbad_pkg::BINIDX_W'(p_bc);
      time_block    <= p_group;
      last_of_group <= p_lastbin;
    end
  end

`ifndef NO_ASSERTIONS
  // Never start a second mean while one is still pending
  a_one_mean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && b_valid && b_last) |-> !div_pend)
    else $error("mean division started while one is pending");

  // Hold the input while a mean is pending
  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    div_pend |-> !in_ready)
    else $error("pixel accepted while a mean is pending");

  // A new result comes only from a finished division
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(avg_wait))
    else $error("result shown without a finished division");

  // The update stage holds only accepted pixels
  a_b_src: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && b_valid) |-> $past(in_valid && in_ready))
    else $error("update stage filled without a transaction");
`endif

endmodule

/* tb/movie_block_average_downsample_test.sv */
`timescale 1ns / 1ps

module movie_block_average_downsample_test;
  import mbad_pkg::*;

  // Run-length guards. The settle and drain waits outlast a division with margin.
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_PIXELS = 1500;
  localparam int unsigned CYCLE_LIMIT   = 6_000_000;
  localparam int unsigned NO_PAUSE      = 32'hFFFF_FFFF;

  // One block mean as it leaves the result port.
  typedef struct packed {
    logic [AVG_W-1:0]    average;
    logic [BINIDX_W-1:0] bin_row;
    logic [BINIDX_W-1:0] bin_col;
    logic [TBLOCK_W-1:0] time_block;
    logic                last_of_group;
  } bin_mean_t;

  localparam bin_mean_t NO_MEAN = '0;

  // One line of the directed script: a register write or a pixel, with the
  // mean typed in where it is obvious.
  typedef struct packed {
    logic                  is_write;
    cfg_reg_t              target;
    logic [CFG_DATA_W-1:0] value;
    logic                  typed;
    bin_mean_t             want;
  } script_row_t;

  // Directed part.
  // Rows 0-14: three pixels under the reset sizes, then a shrink of the frame
  // in mid-movie. The pixel at row 3 lies past the new row count, so it is
  // dropped and the position wraps to the next column, where the first bin
  // completes from pixels taken under both settings.
  // Rows 15-24: every register written as zero acts as one, so each pixel is
  // a bin of its own and its mean is the pixel itself.
  localparam script_row_t SCRIPT [25] = '{
    '{1'b0, REG_ROWS,   16'hFFFF, 1'b0, NO_MEAN},
    '{1'b0, REG_ROWS,   16'hFFFF, 1'b0, NO_MEAN},
    '{1'b0, REG_ROWS,   16'h1234, 1'b0, NO_MEAN},
    '{1'b1, REG_ROWS,   16'd2,    1'b0, NO_MEAN},
    '{1'b1, REG_COLS,   16'd2,    1'b0, NO_MEAN},
    '{1'b1, REG_SPACE,  16'd2,    1'b0, NO_MEAN},
    '{1'b1, REG_TIME,   16'd1,    1'b0, NO_MEAN},
    '{1'b1, REG_FRAMES, 16'd2,    1'b0, NO_MEAN},
    '{1'b0, REG_ROWS,   16'h0000, 1'b0, NO_MEAN},
    '{1'b0, REG_ROWS,   16'hFFFF, 1'b0, NO_MEAN},
    '{1'b0, REG_ROWS,   16'hFFFF, 1'b1, '{16'hFFFF, 10'd0, 10'd0, 16'd0, 1'b1}},
    '{1'b0, REG_ROWS,   16'h0000, 1'b0, NO_MEAN},
    '{1'b0, REG_ROWS,   16'h0000, 1'b0, NO_MEAN},
    '{1'b0, REG_ROWS,   16'h0000, 1'b0, NO_MEAN},
    '{1'b0, REG_ROWS,   16'h0000, 1'b1, '{16'h0000, 10'd0, 10'd0, 16'd1, 1'b1}},
    '{1'b1, REG_ROWS,   16'd0,    1'b0, NO_MEAN},
    '{1'b1, REG_COLS,   16'd0,    1'b0, NO_MEAN},
    '{1'b1, REG_SPACE,  16'd0,    1'b0, NO_MEAN},
    '{1'b1, REG_TIME,   16'd0,    1'b0, NO_MEAN},
    '{1'b1, REG_FRAMES, 16'd0,    1'b0, NO_MEAN},
    '{1'b0, REG_ROWS,   16'hFFFF, 1'b1, '{16'hFFFF, 10'd0, 10'd0, 16'd0, 1'b1}},
    '{1'b0, REG_ROWS,   16'h0000, 1'b1, '{16'h0000, 10'd0, 10'd0, 16'd0, 1'b1}},
    '{1'b0, REG_ROWS,   16'h8000, 1'b1, '{16'h8000, 10'd0, 10'd0, 16'd0, 1'b1}},
    '{1'b0, REG_ROWS,   16'h5555, 1'b1, '{16'h5555, 10'd0, 10'd0, 16'd0, 1'b1}},
    '{1'b0, REG_ROWS,   16'hAAAA, 1'b1, '{16'hAAAA, 10'd0, 10'd0, 16'd0, 1'b1}}
  };

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   sample;
  logic                  out_valid;
  logic                  out_ready;
  logic [AVG_W-1:0]      average;
  logic [BINIDX_W-1:0]   bin_row;
  logic [BINIDX_W-1:0]   bin_col;
  logic [TBLOCK_W-1:0]   time_block;
  logic                  last_of_group;

  // Shadow copy of the registers, as written (masked to register width).
  logic [ROWS_W-1:0]   cfg_rows   = ROWS_W'(ROWS_RESET);
  logic [COLS_W-1:0]   cfg_cols   = COLS_W'(COLS_RESET);
  logic [SF_W-1:0]     cfg_sf     = SF_W'(SF_RESET);
  logic [TF_W-1:0]     cfg_tf     = TF_W'(TF_RESET);
  logic [FRAMES_W-1:0] cfg_frames = FRAMES_W'(FRAMES_RESET);

  // Shadow of the movie position and the bin accumulators.
  bit [29:0]   acc_store [DEFAULT_MAX_BINS];
  int unsigned at_row = 0;
  int unsigned at_col = 0;
  int unsigned frame_in_grp = 0;
  int unsigned grp_idx = 0;
  int unsigned frame_cnt = 0;

  // Block means still owed by the DUT, oldest first.
  bin_mean_t pending_means [$];

  // Pacing controls shared between the sender, the receiver and the script.
  bit calm = 1'b0;      // no gaps on either side while set
  bit hold_out = 1'b0;  // ask the receiver for a long hold-off
  bit settled = 1'b1;   // block known idle, registers may be written

  int unsigned cycle_count = 0;
  int unsigned n_errors = 0;
  int unsigned n_pixels = 0;
  int unsigned n_means = 0;
  int unsigned n_settings = 0;

  movie_block_average_downsample DUT (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Zero and oversized register values map into range.
  function automatic int unsigned limit_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Lean on the extremes so that full-scale sums show up often.
  function automatic logic [SAMPLE_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Fold one accepted pixel into the shadow state. Return 1 with the block
  // mean in res when this pixel closes a bin.
  function automatic bit predict_mean(input logic [SAMPLE_W-1:0] pix, output bin_mean_t res);
    int unsigned r, c, sf, tf, nf, nbr, nbc, br, bc, ngroups, lastaddr, addr, total;
    bit hit, first, last;
    r  = limit_reg(cfg_rows, DEFAULT_MAX_DIM);
    c  = limit_reg(cfg_cols, DEFAULT_MAX_DIM);
    sf = limit_reg(cfg_sf, SF_MAX);
    tf = limit_reg(cfg_tf, TF_MAX);
    nf = limit_reg(cfg_frames, 65535);
    nbr = r / sf;
    nbc = c / sf;
    br = at_row / sf;
    bc = at_col / sf;
    ngroups = nf / tf;
    // Bins past the store are dropped, so the last kept bin closes the frame.
    lastaddr = ((nbr * nbc < DEFAULT_MAX_BINS) ? nbr * nbc : DEFAULT_MAX_BINS) - 1;
    hit = 1'b0;
    res = '0;

    // Drop partial edge blocks and trailing frames.
    if (br < nbr && bc < nbc && grp_idx < ngroups) begin
      addr = br + nbr * bc;
      if (addr < DEFAULT_MAX_BINS) begin
        first = frame_in_grp == 0 && at_row % sf == 0 && at_col % sf == 0;
        last  = frame_in_grp == tf - 1 && at_row % sf == sf - 1 && at_col % sf == sf - 1;
        // The first pixel of a group overwrites the accumulator.
        total = first ? pix : acc_store[addr] + pix;
        acc_store[addr] = 30'(total);
        if (last) begin
          res.average       = AVG_W'(total / (sf * sf * tf));
          res.bin_row       = BINIDX_W'(br);
          res.bin_col       = BINIDX_W'(bc);
          res.time_block    = TBLOCK_W'(grp_idx);
          res.last_of_group = (addr == lastaddr);
          hit = 1'b1;
        end
      end
    end

    // Advance the position; a position past a shrunken size wraps here.
    at_row++;
    if (at_row >= r) begin
      at_row = 0;
      at_col++;
      if (at_col >= c) begin
        at_col = 0;
        frame_cnt++;
        frame_in_grp++;
        if (frame_in_grp >= tf) begin
          frame_in_grp = 0;
          grp_idx = (grp_idx + 1) & 16'hFFFF;
        end
        if (frame_cnt >= nf) begin
          frame_cnt = 0;
          frame_in_grp = 0;
          grp_idx = 0;
        end
      end
    end
    return hit;
  endfunction

  // Offer one pixel transaction after a random gap and hold it until taken.
  // Enter and leave at a falling edge; valid stays high on return so that
  // a back-to-back transaction never drops it.
  task automatic send_pixel(input logic [SAMPLE_W-1:0] v, input bit typed,
                            input bin_mean_t want);
    int unsigned gap;
    bin_mean_t calc;
    bit hit;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    sample = v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hit = predict_mean(v, calc);
    // Typed rows carry their own expectation; the shadow state still advances.
    if (typed) pending_means.push_back(want);
    else if (hit) pending_means.push_back(calc);
    n_pixels++;
    settled = 1'b0;
    @(negedge clk);
  endtask

  // Write one register. Drain first: a pixel that closes no bin can leave
  // the block busy after the last mean, so wait out the divider too.
  task automatic write_reg(input cfg_reg_t target, input logic [CFG_DATA_W-1:0] value);
    in_valid = 1'b0;
    if (!settled) begin
      while (pending_means.size() != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
      settled = 1'b1;
    end
    cfg_write = 1'b1;
    cfg_index = target;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    case (target)
      REG_ROWS:   cfg_rows   = value[ROWS_W-1:0];
      REG_COLS:   cfg_cols   = value[COLS_W-1:0];
      REG_SPACE:  cfg_sf     = value[SF_W-1:0];
      REG_TIME:   cfg_tf     = value[TF_W-1:0];
      REG_FRAMES: cfg_frames = value[FRAMES_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_movie(input int unsigned r, input int unsigned c, input int unsigned sf,
                           input int unsigned tf, input int unsigned nf);
    write_reg(REG_ROWS,   CFG_DATA_W'(r));
    write_reg(REG_COLS,   CFG_DATA_W'(c));
    write_reg(REG_SPACE,  CFG_DATA_W'(sf));
    write_reg(REG_TIME,   CFG_DATA_W'(tf));
    write_reg(REG_FRAMES, CFG_DATA_W'(nf));
    n_settings++;
  endtask

  // Stream one whole movie so the position counters end back at zero and no
  // later bin can close without its first pixel. Now and then (and at
  // pause_at) hold the sender until every owed mean has come back.
  task automatic play_movie(input int unsigned pause_at);
    int unsigned npix;
    npix = limit_reg(cfg_rows, DEFAULT_MAX_DIM) * limit_reg(cfg_cols, DEFAULT_MAX_DIM)
         * limit_reg(cfg_frames, 65535);
    for (int unsigned k = 0; k < npix; k++) begin
      if (k == pause_at || $urandom_range(0, 249) == 0) begin
        in_valid = 1'b0;
        while (pending_means.size() != 0) @(negedge clk);
      end
      send_pixel(rand_pixel(), 1'b0, NO_MEAN);
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, what, want, got);
      n_errors++;
    end
  endtask

  // Receiver: random stalls, a long hold-off on request, none while calm.
  initial begin : result_pacing
    int unsigned stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        // Hold off long enough for the block to fill and push back on input.
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end
      if (calm) begin
        out_ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        out_ready = (stall_left == 0);
      end
    end
  end

  // Compare each result transaction with the oldest owed mean.
  always @(posedge clk) begin : result_check
    bin_mean_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected result average %h bin (%0d,%0d) block %0d last %b",
                 $time, average, bin_row, bin_col, time_block, last_of_group);
        n_errors++;
      end else begin
        want = pending_means.pop_front();
        check_field("average", want.average, average);
        check_field("bin_row", want.bin_row, bin_row);
        check_field("bin_col", want.bin_col, bin_col);
        check_field("time_block", want.time_block, time_block);
        check_field("last_of_group", want.last_of_group, last_of_group);
        n_means++;
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d means still owed", $time, pending_means.size());
      $display("[movie_block_average_downsample] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    script_row_t row;
    int unsigned random_start;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_ROWS;
    cfg_data  = '0;
    in_valid  = 1'b0;
    sample    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed script.
    foreach (SCRIPT[i]) begin
      row = SCRIPT[i];
      if (row.is_write) write_reg(row.target, row.value);
      else send_pixel(row.value, row.typed, row.want);
    end
    n_settings += 2;

    // Random small movies: odd sizes give partial edge blocks, frame counts
    // off the group size give trailing frames, zero registers act as one.
    random_start = n_pixels;
    while (n_pixels - random_start < RANDOM_PIXELS) begin
      calm = ($urandom_range(0, 3) == 0);
      set_movie($urandom_range(0, 10), $urandom_range(0, 10), $urandom_range(0, 5),
                $urandom_range(0, 3), $urandom_range(0, 6));
      play_movie(NO_PAUSE);
    end

    // Extreme settings.
    calm = 1'b0;
    // Oversized block edge saturates at 16; row 16 is a partial edge.
    set_movie(17, 16, 31, 1, 1);
    play_movie(NO_PAUSE);
    // Oversized group length saturates at 64; the last two frames trail.
    set_movie(1, 1, 1, 127, 130);
    play_movie(NO_PAUSE);
    // Oversized column count saturates; hold off the output, then later
    // hold the sender until all owed means are back.
    set_movie(1, 2047, 1, 1, 1);
    hold_out = 1'b1;
    play_movie(700);
    // Oversized row count with more bins than the store holds.
    set_movie(2047, 5, 1, 1, 1);
    hold_out = 1'b1;
    play_movie(NO_PAUSE);

    // Drain, then give the block time to show any stray result.
    in_valid = 1'b0;
    while (pending_means.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d block means from %0d pixel transactions over %0d register settings,",
             n_means, n_pixels, n_settings);
    $display("with mid-movie resizing, zero and oversized registers, edge and trailing drops.");
    if (n_errors == 0) begin
      $display("[movie_block_average_downsample] OK");
    end else begin
      $display("[movie_block_average_downsample] ERROR");
    end
    $finish;
  end

endmodule
